[hw/rtl/aat_pkg.sv]
// Shared constants for the axis-aligned box affine transform block.
// Used by the channel interfaces, the top level and the checker.
package aat_pkg;

    localparam int COORD_W    = 32;
    localparam int COEF_W     = 16;
    localparam int ROW_W      = 3 * COEF_W;
    localparam int FRAC_SHIFT = 29;
    localparam int ACC_W      = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = ROW_W;

    localparam logic [CFG_IDX_W-1:0] CFG_COEF_ROW_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_ROW_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_ROW_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_X    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_Y    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_Z    = 3'd5;

    localparam logic [ROW_W-1:0] COEF_ROW_X_RST = 48'h0000_0000_1000;
    localparam logic [ROW_W-1:0] COEF_ROW_Y_RST = 48'h0000_1000_0000;
    localparam logic [ROW_W-1:0] COEF_ROW_Z_RST = 48'h1000_0000_0000;

endpackage

[hw/rtl/aat_box_if.sv]
// Input channel carrying one box transaction: corners and valid flag.
// Depends on aat_pkg for the coordinate width.
interface aat_box_if;
    logic                                valid;
    logic                                ready;
    logic signed [aat_pkg::COORD_W-1:0]  lo_x;
    logic signed [aat_pkg::COORD_W-1:0]  lo_y;
    logic signed [aat_pkg::COORD_W-1:0]  lo_z;
    logic signed [aat_pkg::COORD_W-1:0]  hi_x;
    logic signed [aat_pkg::COORD_W-1:0]  hi_y;
    logic signed [aat_pkg::COORD_W-1:0]  hi_z;
    logic                                box_ok;

    modport source (output valid, lo_x, lo_y, lo_z, hi_x, hi_y, hi_z, box_ok, input ready);
    modport sink   (input valid, lo_x, lo_y, lo_z, hi_x, hi_y, hi_z, box_ok, output ready);
endinterface

[hw/rtl/aat_res_if.sv]
// Output channel carrying one transformed box transaction.
// Depends on aat_pkg for the coordinate width.
interface aat_res_if;
    logic                                valid;
    logic                                ready;
    logic signed [aat_pkg::COORD_W-1:0]  new_lo_x;
    logic signed [aat_pkg::COORD_W-1:0]  new_lo_y;
    logic signed [aat_pkg::COORD_W-1:0]  new_lo_z;
    logic signed [aat_pkg::COORD_W-1:0]  new_hi_x;
    logic signed [aat_pkg::COORD_W-1:0]  new_hi_y;
    logic signed [aat_pkg::COORD_W-1:0]  new_hi_z;
    logic                                new_ok;

    modport source (output valid, new_lo_x, new_lo_y, new_lo_z, new_hi_x, new_hi_y, new_hi_z,
                    new_ok, input ready);
    modport sink   (input valid, new_lo_x, new_lo_y, new_lo_z, new_hi_x, new_hi_y, new_hi_z,
                    new_ok, output ready);
endinterface

[hw/rtl/aabb_affine_transform.sv]
// Top level of the axis-aligned box affine transform block.
// Depends on aat_pkg, aat_box_if and aat_res_if.

// The block accepts one box transaction per clock unless the result channel
// stalls, and returns its transformed bounding box through a seven-stage
// pipeline: corner sum and difference, the eighteen coefficient products,
// magnitude and partial centre sums, two reduction stages, corner formation,
// and rounding with saturation into the output register. A stall on the
// result channel holds the whole pipeline in place; while the output register
// is empty or being drained the block keeps taking a new transaction every
// cycle. Configuration writes must be made while no transaction is in flight.
module aabb_affine_transform (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [aat_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [aat_pkg::CFG_DATA_W-1:0]    cfg_data,
    aat_box_if.sink                           box_in,
    aat_res_if.source                         res_out
);

    localparam int CW    = aat_pkg::COORD_W;
    localparam int KW    = aat_pkg::COEF_W;
    localparam int SW    = CW + 1;
    localparam int PW    = SW + KW;
    localparam int EW    = PW - 1;
    localparam int XW    = EW + 2;
    localparam int AW    = aat_pkg::ACC_W;
    localparam int FS    = aat_pkg::FRAC_SHIFT;
    localparam int NSTG  = 7;

    localparam logic signed [AW-1:0] RND_MASK = (AW'(1) <<< FS) - AW'(1);
    localparam logic signed [AW-1:0] SAT_MAX  = AW'((64'(1) << (CW - 1)) - 64'(1));
    localparam logic signed [AW-1:0] SAT_MIN  = -(AW'(1) <<< (CW - 1));

    function automatic logic signed [CW-1:0] round_sat(input logic signed [AW-1:0] v);
        logic signed [AW-1:0] q;
        q = v >>> FS;
        if (q > SAT_MAX)
            return SAT_MAX[CW-1:0];
        else if (q < SAT_MIN)
            return SAT_MIN[CW-1:0];
        else
            return q[CW-1:0];
    endfunction

    logic [aat_pkg::ROW_W-1:0]  coef_row_reg [3];
    logic signed [CW-1:0]       shift_reg    [3];

    logic [NSTG:1]  vld_reg;
    logic [NSTG:1]  ok_reg;
    logic           adv;

    logic signed [SW-1:0]  s1_sum_reg [3];
    logic signed [SW-1:0]  s1_dif_reg [3];
    logic signed [SW-1:0]  s1_sum_next [3];
    logic signed [SW-1:0]  s1_dif_next [3];

    logic signed [PW-1:0]  s2_cp_reg  [3][3];
    logic signed [PW-1:0]  s2_ep_reg  [3][3];
    logic signed [PW-1:0]  s2_cp_next [3][3];
    logic signed [PW-1:0]  s2_ep_next [3][3];

    logic signed [AW-1:0]  s3_ca_reg  [3];
    logic signed [AW-1:0]  s3_cb_reg  [3];
    logic [EW-1:0]         s3_ea_reg  [3][3];
    logic signed [AW-1:0]  s3_ca_next [3];
    logic signed [AW-1:0]  s3_cb_next [3];
    logic [EW-1:0]         s3_ea_next [3][3];

    logic signed [AW-1:0]  s4_cen_reg  [3];
    logic [XW-1:0]         s4_xa_reg   [3];
    logic [XW-1:0]         s4_xb_reg   [3];
    logic signed [AW-1:0]  s4_cen_next [3];
    logic [XW-1:0]         s4_xa_next  [3];
    logic [XW-1:0]         s4_xb_next  [3];

    logic signed [AW-1:0]  s5_cen_reg  [3];
    logic [XW-1:0]         s5_ext_reg  [3];
    logic [XW-1:0]         s5_ext_next [3];

    logic signed [AW-1:0]  s6_lo_reg  [3];
    logic signed [AW-1:0]  s6_hi_reg  [3];
    logic signed [AW-1:0]  s6_lo_next [3];
    logic signed [AW-1:0]  s6_hi_next [3];

    logic signed [CW-1:0]  s7_lo_reg  [3];
    logic signed [CW-1:0]  s7_hi_reg  [3];
    logic signed [CW-1:0]  s7_lo_next [3];
    logic signed [CW-1:0]  s7_hi_next [3];

    logic signed [CW-1:0]  in_lo [3];
    logic signed [CW-1:0]  in_hi [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_row_reg[0] <= aat_pkg::COEF_ROW_X_RST;
            coef_row_reg[1] <= aat_pkg::COEF_ROW_Y_RST;
            coef_row_reg[2] <= aat_pkg::COEF_ROW_Z_RST;
            shift_reg[0]    <= '0;
            shift_reg[1]    <= '0;
            shift_reg[2]    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                aat_pkg::CFG_COEF_ROW_X: coef_row_reg[0] <= cfg_data;
                aat_pkg::CFG_COEF_ROW_Y: coef_row_reg[1] <= cfg_data;
                aat_pkg::CFG_COEF_ROW_Z: coef_row_reg[2] <= cfg_data;
                aat_pkg::CFG_SHIFT_X:    shift_reg[0]    <= cfg_data[CW-1:0];
                aat_pkg::CFG_SHIFT_Y:    shift_reg[1]    <= cfg_data[CW-1:0];
                aat_pkg::CFG_SHIFT_Z:    shift_reg[2]    <= cfg_data[CW-1:0];
                default: ;
            endcase
        end
    end

    assign adv          = !vld_reg[NSTG] || res_out.ready;
    assign box_in.ready = adv;

    assign in_lo[0] = box_in.lo_x;
    assign in_lo[1] = box_in.lo_y;
    assign in_lo[2] = box_in.lo_z;
    assign in_hi[0] = box_in.hi_x;
    assign in_hi[1] = box_in.hi_y;
    assign in_hi[2] = box_in.hi_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            ok_reg  <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NSTG-1:1], box_in.valid};
            ok_reg  <= {ok_reg[NSTG-1:1], box_in.box_ok};
        end
    end

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            s1_sum_next[a] = {in_hi[a][CW-1], in_hi[a]} + {in_lo[a][CW-1], in_lo[a]};
            s1_dif_next[a] = {in_hi[a][CW-1], in_hi[a]} - {in_lo[a][CW-1], in_lo[a]};
        end
    end

    // Product index order is [output axis][input axis].
    always_comb
    begin
        for (int o = 0; o < 3; o++)
        begin
            for (int a = 0; a < 3; a++)
            begin
                s2_cp_next[o][a] = PW'(s1_sum_reg[a] * $signed(coef_row_reg[a][KW*o +: KW]));
                s2_ep_next[o][a] = PW'(s1_dif_reg[a] * $signed(coef_row_reg[a][KW*o +: KW]));
            end
        end
    end

    always_comb
    begin
        for (int o = 0; o < 3; o++)
        begin
            s3_ca_next[o] = AW'(s2_cp_reg[o][0]) + AW'(s2_cp_reg[o][1]);
            s3_cb_next[o] = AW'(s2_cp_reg[o][2]) + (AW'(shift_reg[o]) <<< FS);
            for (int a = 0; a < 3; a++)
            begin
                s3_ea_next[o][a] = s2_ep_reg[o][a][PW-1] ? EW'(-s2_ep_reg[o][a])
                                                         : EW'(s2_ep_reg[o][a]);
            end
        end
    end

    always_comb
    begin
        for (int o = 0; o < 3; o++)
        begin
            s4_cen_next[o] = s3_ca_reg[o] + s3_cb_reg[o];
            s4_xa_next[o]  = XW'(s3_ea_reg[o][0]) + XW'(s3_ea_reg[o][1]);
            s4_xb_next[o]  = XW'(s3_ea_reg[o][2]);
            s5_ext_next[o] = s4_xa_reg[o] + s4_xb_reg[o];
            s6_lo_next[o]  = s5_cen_reg[o] - AW'(s5_ext_reg[o]);
            s6_hi_next[o]  = s5_cen_reg[o] + AW'(s5_ext_reg[o]) + RND_MASK;
            s7_lo_next[o]  = ok_reg[6] ? round_sat(s6_lo_reg[o]) : '0;
            s7_hi_next[o]  = ok_reg[6] ? round_sat(s6_hi_reg[o]) : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_sum_reg  <= s1_sum_next;
            s1_dif_reg  <= s1_dif_next;
            s2_cp_reg   <= s2_cp_next;
            s2_ep_reg   <= s2_ep_next;
            s3_ca_reg   <= s3_ca_next;
            s3_cb_reg   <= s3_cb_next;
            s3_ea_reg   <= s3_ea_next;
            s4_cen_reg  <= s4_cen_next;
            s4_xa_reg   <= s4_xa_next;
            s4_xb_reg   <= s4_xb_next;
            s5_cen_reg  <= s4_cen_reg;
            s5_ext_reg  <= s5_ext_next;
            s6_lo_reg   <= s6_lo_next;
            s6_hi_reg   <= s6_hi_next;
            s7_lo_reg   <= s7_lo_next;
            s7_hi_reg   <= s7_hi_next;
        end
    end

    assign res_out.valid    = vld_reg[NSTG];
    assign res_out.new_ok   = ok_reg[NSTG];
    assign res_out.new_lo_x = s7_lo_reg[0];
    assign res_out.new_lo_y = s7_lo_reg[1];
    assign res_out.new_lo_z = s7_lo_reg[2];
    assign res_out.new_hi_x = s7_hi_reg[0];
    assign res_out.new_hi_y = s7_hi_reg[1];
    assign res_out.new_hi_z = s7_hi_reg[2];

endmodule

[hw/rtl/aat_checker.sv]
// Port-level checks for the axis-aligned box affine transform block.
// Depends on aat_pkg; bound to aabb_affine_transform at the end of this file.
module aat_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_ready,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic signed [aat_pkg::COORD_W-1:0] lo_x,
    input  logic signed [aat_pkg::COORD_W-1:0] lo_y,
    input  logic signed [aat_pkg::COORD_W-1:0] lo_z,
    input  logic signed [aat_pkg::COORD_W-1:0] hi_x,
    input  logic signed [aat_pkg::COORD_W-1:0] hi_y,
    input  logic signed [aat_pkg::COORD_W-1:0] hi_z,
    input  logic                              ok
);

    // A stalled result transaction stays valid and keeps its lo_x, hi_z and ok values.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(lo_x) && $stable(hi_z) && $stable(ok))
        else $error("stalled result changed");

    // An invalid box comes out with all corners cleared.
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !ok |-> lo_x == 0 && lo_y == 0 && lo_z == 0 &&
                             hi_x == 0 && hi_y == 0 && hi_z == 0)
        else $error("invalid result has nonzero corners");

    // A valid result always has its minimum corner at or below its maximum corner.
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ok |-> lo_x <= hi_x && lo_y <= hi_y && lo_z <= hi_z)
        else $error("result corners out of order");

    // With the output register empty the pipeline must be taking input.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

endmodule

bind aabb_affine_transform aat_checker u_aat_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (box_in.ready),
    .out_valid (res_out.valid),
    .out_ready (res_out.ready),
    .lo_x      (res_out.new_lo_x),
    .lo_y      (res_out.new_lo_y),
    .lo_z      (res_out.new_lo_z),
    .hi_x      (res_out.new_hi_x),
    .hi_y      (res_out.new_hi_y),
    .hi_z      (res_out.new_hi_z),
    .ok        (res_out.new_ok)
);
